// ===== rtl/knn_pkg.sv =====
// Package for the nearest-neighbor classifier: payload structs and constants.
// No dependencies.
`timescale 1ns / 1ps
package knn_pkg;
  localparam int MAX_POINTS = 256;
  localparam int MAX_K = 8;
  localparam int FEAT_W = 16;
  localparam int LABEL_W = 8;
  localparam int DIST_W = 35;
  localparam int K_W = 4;
  localparam int COUNT_W = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_K = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 1'b1;

  typedef struct packed {
    logic action;
    logic [7:0] index;
    logic signed [FEAT_W-1:0] feature_0;
    logic signed [FEAT_W-1:0] feature_1;
    logic signed [FEAT_W-1:0] feature_2;
    logic signed [FEAT_W-1:0] feature_3;
    logic [LABEL_W-1:0] label;
  } in_word_t;

  typedef struct packed {
    logic [LABEL_W-1:0] predicted_label;
    logic [K_W-1:0] vote_count;
  } out_word_t;
endpackage

// ===== rtl/knn_majority_classifier.sv =====
// Top level of the k-nearest-neighbor classifier with training memory.
// Depends on knn_pkg and knn_vote.
//
// Usage: in_valid/in_ready carry an input word. A load (action 0) writes
// one training entry into the point memory and gives no result. A query
// (action 1) streams the first point_count entries out of the memory,
// one per cycle, through a two-stage distance pipeline (register after
// the squares, then the sum) and an insertion list of the k nearest.
// Then a vote walks the list, one neighbor per cycle, and out_valid
// rises with the result. The next word is taken in the cycle after the
// result word is accepted.
// The result word waits in an output register on out_valid/out_ready;
// a stalled receiver holds the block before its next item only.
// Configuration writes on cfg_valid/cfg_ready are always taken.
// Reset sets k to 3 and point_count to 256. The memory is not cleared:
// querying an entry never loaded gives an undefined answer.
`timescale 1ns / 1ps
module knn_majority_classifier (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  input knn_pkg::in_word_t in_data,
  output logic out_valid,
  input logic out_ready,
  output knn_pkg::out_word_t out_data,
  input logic cfg_valid,
  output logic cfg_ready,
  input logic [knn_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [knn_pkg::CFG_DATA_W-1:0] cfg_data
);
  import knn_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int KI = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam logic [2:0] ST_IDLE = 3'd0, ST_SCAN = 3'd1, ST_DRAIN = 3'd2,
    ST_VOTE = 3'd3, ST_OUT = 3'd4;

  logic [K_W-1:0] reg_k;
  logic [COUNT_W-1:0] reg_point_count;
  logic [2:0] state;
  logic [4*FEAT_W-1:0] point_mem [MAX_POINTS];
  logic [LABEL_W-1:0] label_mem [MAX_POINTS];
  logic [4*FEAT_W-1:0] rd_point;
  logic [LABEL_W-1:0] rd_label;
  in_word_t query;
  logic [AW:0] rd_addr;
  logic [AW:0] count;
  logic [3:0] kk;
  logic rd_v, sq_v, dist_v;
  logic [33:0] sq [4];
  logic [LABEL_W-1:0] sq_label, dist_label;
  logic [DIST_W-1:0] dist_sum;
  logic [MAX_K-1:0][DIST_W-1:0] best_d;
  logic [MAX_K-1:0][LABEL_W-1:0] best_l;
  logic [3:0] filled;
  logic [2:0] drain;
  logic vote_start, vote_done;
  out_word_t vote_res;

  assign cfg_ready = 1'b1;
  assign in_ready = (state == ST_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_k <= 4'd3;
      reg_point_count <= 9'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_K: reg_k <= cfg_data[K_W-1:0];
        REG_POINT_COUNT: reg_point_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Training memory: write on load, synchronous read during scan.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_data.action == ACT_LOAD &&
        {1'b0, in_data.index} < 9'(MAX_POINTS)) begin
      point_mem[in_data.index[AW-1:0]] <= {in_data.feature_0, in_data.feature_1,
                                           in_data.feature_2, in_data.feature_3};
      label_mem[in_data.index[AW-1:0]] <= in_data.label;
    end
    rd_point <= point_mem[rd_addr[AW-1:0]];
    rd_label <= label_mem[rd_addr[AW-1:0]];
  end

  // Squared differences, registered, then summed.
  always_ff @(posedge clk) begin
    logic signed [FEAT_W:0] df;
    logic signed [2*FEAT_W+1:0] prod;
    for (int d = 0; d < 4; d++) begin
      df = 17'(signed'(query[LABEL_W + FEAT_W*d +: FEAT_W]))
         - 17'(signed'(rd_point[FEAT_W*d +: FEAT_W]));
      prod = df * df;
      sq[d] <= prod;
    end
    sq_label <= rd_label;
    dist_sum <= 35'(sq[0]) + 35'(sq[1]) + 35'(sq[2]) + 35'(sq[3]);
    dist_label <= sq_label;
  end

  // Insertion into the sorted list; strict compare keeps the lower index.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rd_v <= 1'b0;
      sq_v <= 1'b0;
      dist_v <= 1'b0;
      out_valid <= 1'b0;
      vote_start <= 1'b0;
      filled <= '0;
    end else begin
      vote_start <= 1'b0;
      sq_v <= rd_v;
      dist_v <= sq_v;
      rd_v <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (dist_v) begin
        for (int p = 0; p < MAX_K; p++) begin
          if (4'(p) < kk) begin
            if (best_d[p] > dist_sum) begin
              if (p == 0 || !(best_d[KI'(p-1)] > dist_sum)) begin
                best_d[p] <= dist_sum;
                best_l[p] <= dist_label;
              end else begin
                best_d[p] <= best_d[KI'(p-1)];
                best_l[p] <= best_l[KI'(p-1)];
              end
            end
          end
        end
        if (filled < kk) filled <= filled + 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready && in_data.action == ACT_QUERY) begin
            query <= in_data;
            kk <= (reg_k == 0) ? 4'd1 : (reg_k > 4'(MAX_K)) ? 4'(MAX_K) : reg_k;
            count <= (reg_point_count > 9'(MAX_POINTS)) ? (AW+1)'(MAX_POINTS)
                                                          : (AW+1)'(reg_point_count);
            rd_addr <= '0;
            filled <= '0;
            for (int p = 0; p < MAX_K; p++) begin
              best_d[p] <= '1;
              best_l[p] <= '0;
            end
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_addr < count) begin
            rd_v <= 1'b1;
            rd_addr <= rd_addr + 1'b1;
          end else begin
            drain <= '0;
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          drain <= drain + 1'b1;
          if (drain == 3'd4) begin
            vote_start <= 1'b1;
            state <= ST_VOTE;
          end
        end
        ST_VOTE: begin
          if (vote_done) begin
            out_data <= vote_res;
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  knn_vote u_vote (
    .clk(clk), .rst(rst), .start(vote_start), .filled(filled),
    .labels(best_l), .done(vote_done), .result(vote_res)
  );

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE) else $error("ready outside idle");
  a_filled_le_k: assert property (@(posedge clk) disable iff (rst)
    state == ST_VOTE |-> filled <= kk) else $error("list overfilled");
  a_vote_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_VOTE && vote_done) |=> out_valid) else $error("result lost");
endmodule

// ===== rtl/knn_vote.sv =====
// Majority vote over the sorted neighbor list, one candidate per cycle.
// Depends on knn_pkg.
`timescale 1ns / 1ps
module knn_vote (
  input logic clk,
  input logic rst,
  input logic start,
  input logic [3:0] filled,
  input logic [knn_pkg::MAX_K-1:0][knn_pkg::LABEL_W-1:0] labels,
  output logic done,
  output knn_pkg::out_word_t result
);
  import knn_pkg::*;

  logic busy;
  logic [3:0] n;
  logic [LABEL_W-1:0] best_lab;
  logic [K_W-1:0] best_votes;
  logic [K_W-1:0] votes;
  logic [LABEL_W-1:0] cand;

  always_comb begin
    cand = labels[n[$clog2(MAX_K > 1 ? MAX_K : 2)-1:0]];
    votes = '0;
    for (int m = 0; m < MAX_K; m++) begin
      if (4'(m) < filled && labels[m] == cand) votes = votes + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      n <= '0;
    end else if (start) begin
      busy <= 1'b1;
      n <= '0;
      best_lab <= '0;
      best_votes <= '0;
    end else if (busy) begin
      if (n >= filled) begin
        busy <= 1'b0;
        done <= 1'b1;
        result.predicted_label <= best_lab;
        result.vote_count <= best_votes;
      end else begin
        if (votes > best_votes || (votes == best_votes && cand < best_lab)) begin
          best_votes <= votes;
          best_lab <= cand;
        end
        n <= n + 1'b1;
      end
    end
  end
endmodule
